// ----- hdl/assert_macros.svh -----
// Assertion macros used by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/rhsm_pkg.sv -----
// Shared types, constants and helpers of the rolling hash matcher.
`timescale 1ns / 1ps
package rhsm_pkg;
	localparam int MAX_PATTERN = 64;
	localparam int PIDX_W      = $clog2(MAX_PATTERN);
	localparam int PCNT_W      = $clog2(MAX_PATTERN + 1);
	localparam int POS_W       = 24;
	localparam int HASH_W      = 16;
	localparam int CHAR_W      = 8;
	localparam int OP_W        = 2;
	localparam int CFG_W       = 32;
	localparam logic [HASH_W-1:0] BASE_RST = 16'd7000;
	localparam logic [HASH_W-1:0] MOD_RST  = 16'd7069;
	localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

	localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
	localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CHAR_W-1:0] chr;
	} item_t;

	typedef struct packed {
		logic [HASH_W-1:0] base;
		logic [HASH_W-1:0] modulus;
	} cfg_t;

	// Reduce a value below twice the modulus.
	function automatic logic [HASH_W-1:0] mod_fix(input logic [HASH_W:0] v,
			input logic [HASH_W-1:0] m);
		logic [HASH_W:0] d;
		begin
			d = v - {1'b0, m};
			mod_fix = (v >= {1'b0, m}) ? d[HASH_W-1:0] : v[HASH_W-1:0];
		end
	endfunction
endpackage

// ----- hdl/rolling_hash_substring_matcher_unit.sv -----
// Top level of the streaming rolling hash substring matcher.
`timescale 1ns / 1ps
// Streaming Rabin-Karp matcher. Items carry an opcode (append pattern byte, text
// byte, restart) and a byte; each text item gives one result with a match flag
// and the window start position, other items give none. All modular products
// go through one bit-serial multiplier. A text item does extra products once the
// window fills and the outgoing byte is removed, compares the window with the
// pattern byte by byte when the hashes agree, and may wait for the previous
// result to leave. A restart is handled in the idle state without the multiplier.
// A two-entry queue decouples input acceptance from execution,
// and a result register lets the next item start while a result waits.
// hash_base is at byte address 0 and hash_modulus at 4; write them only while idle.
module rolling_hash_substring_matcher_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [rhsm_pkg::CFG_W-1:0]    pwdata,
	output logic [rhsm_pkg::CFG_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rhsm_pkg::OP_W-1:0]     opcode,
	input  logic [rhsm_pkg::CHAR_W-1:0]   in_char,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          match_found,
	output logic [rhsm_pkg::POS_W-1:0]    start_position
);
	rhsm_pkg::cfg_t  cfg_q;
	rhsm_pkg::item_t q_item;
	logic            q_valid, q_pop;

	assign pready = 1'b1;
	assign prdata = {{(rhsm_pkg::CFG_W-rhsm_pkg::HASH_W){1'b0}},
		paddr[2] ? cfg_q.modulus : cfg_q.base};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base    <= rhsm_pkg::BASE_RST;
			cfg_q.modulus <= rhsm_pkg::MOD_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) cfg_q.modulus <= pwdata[rhsm_pkg::HASH_W-1:0];
			else cfg_q.base <= pwdata[rhsm_pkg::HASH_W-1:0];
		end
	end

	rhsm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .in_char(in_char), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop)
	);

	rhsm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
		.match_found(match_found), .start_position(start_position)
	);
endmodule

// ----- hdl/rhsm_front.sv -----
// Input side: accepts items, drops unused opcodes and queues the rest.
`timescale 1ns / 1ps
module rhsm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rhsm_pkg::OP_W-1:0]     opcode,
	input  logic [rhsm_pkg::CHAR_W-1:0]   in_char,
	output logic                          q_valid,
	output rhsm_pkg::item_t               q_item,
	input  logic                          q_pop
);
	rhsm_pkg::item_t slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       wr_q;
	logic       acc, keep, pop;

	assign in_stall = (cnt_q == 2'd2);
	assign acc      = in_valid && !in_stall;
	assign keep     = acc && (opcode == rhsm_pkg::OP_APPEND || opcode == rhsm_pkg::OP_TEXT ||
		opcode == rhsm_pkg::OP_RESTART);
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			slot_q[wr_q].op  <= opcode;
			slot_q[wr_q].chr <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (keep) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, keep} - {1'b0, pop};
		end
	end
endmodule

// ----- hdl/rhsm_mulmod.sv -----
// Bit-serial modular multiplier: r = x * y mod m, x below m, one bit of y a cycle.
`timescale 1ns / 1ps
module rhsm_mulmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rhsm_pkg::HASH_W-1:0]   m,
	input  logic [rhsm_pkg::HASH_W-1:0]   x,
	input  logic [rhsm_pkg::HASH_W-1:0]   y,
	output logic                          done,
	output logic [rhsm_pkg::HASH_W-1:0]   r
);
	localparam int CW = $clog2(rhsm_pkg::HASH_W);
	logic                        busy_q, done_q;
	logic [CW-1:0]               cnt_q;
	logic [rhsm_pkg::HASH_W-1:0] r_q, x_q, y_q, d1, d2;

	always_comb begin
		d1 = rhsm_pkg::mod_fix({r_q, 1'b0}, m);
		d2 = y_q[cnt_q] ? rhsm_pkg::mod_fix({1'b0, d1} + {1'b0, x_q}, m) : d1;
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x_q <= x;
			y_q <= y;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= d2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(rhsm_pkg::HASH_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign r    = r_q;
endmodule

// ----- hdl/rhsm_back.sv -----
// Execution side: hash sequencer, pattern and window memories, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rhsm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rhsm_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	input  rhsm_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          match_found,
	output logic [rhsm_pkg::POS_W-1:0]    start_position
);
	localparam int HW = rhsm_pkg::HASH_W;
	localparam int PW = rhsm_pkg::POS_W;
	localparam int IW = rhsm_pkg::PIDX_W;
	localparam int NW = rhsm_pkg::PCNT_W;
	localparam int CW = rhsm_pkg::CHAR_W;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_RB   = 12'b000000000010,
		ST_RC   = 12'b000000000100,
		ST_MH   = 12'b000000001000,
		ST_MP   = 12'b000000010000,
		ST_RP   = 12'b000000100000,
		ST_MS   = 12'b000001000000,
		ST_WR   = 12'b000010000000,
		ST_RH   = 12'b000100000000,
		ST_CMP  = 12'b001000000000,
		ST_CHK  = 12'b010000000000,
		ST_OUT  = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [NW-1:0] pcount_q, i_q;
	logic [HW-1:0] phash_q, bpow_q, whash_q, b_q, c_q, t_q, bpr_q;
	logic [PW-1:0] pos_q, start_q;
	logic [IW-1:0] rptr_q;
	logic [CW-1:0] chr_q, old_q;
	logic          app_q, issued_q, hit_q;
	logic          oval_q, omatch_q;
	logic [PW-1:0] opos_q;

	logic [CW-1:0] pmem [rhsm_pkg::MAX_PATTERN];
	logic [CW-1:0] wmem [rhsm_pkg::MAX_PATTERN];
	logic [CW-1:0] prd_q, wrd_q;
	logic [IW-1:0] prd_a, wrd_a, wbase;

	logic [HW-1:0] m, mm_x, mm_y, mm_r, sum_c, sub_r;
	logic          mm_start, mm_done, mm_state, out_free;
	logic [PW:0]   pos1, st_calc;

	assign m = (cfg.modulus < 16'd2) ? 16'd2 : cfg.modulus;

	rhsm_mulmod u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .m(m),
		.x(mm_x), .y(mm_y), .done(mm_done), .r(mm_r)
	);

	always_comb begin
		mm_state = 1'b1;
		mm_x     = 16'd1;
		mm_y     = cfg.base;
		case (state_q)
			ST_RB: mm_y = cfg.base;
			ST_RC: mm_y = {{(HW-CW){1'b0}}, chr_q};
			ST_MH: begin
				mm_x = b_q;
				mm_y = app_q ? phash_q : whash_q;
			end
			ST_MP: begin
				mm_x = b_q;
				mm_y = bpow_q;
			end
			ST_RP: mm_y = bpow_q;
			ST_MS: begin
				mm_x = bpr_q;
				mm_y = {{(HW-CW){1'b0}}, old_q};
			end
			ST_RH: mm_y = phash_q;
			default: mm_state = 1'b0;
		endcase
	end
	assign mm_start = mm_state && !issued_q;

	assign sum_c   = rhsm_pkg::mod_fix({1'b0, mm_r} + {1'b0, c_q}, m);
	// t + m - sub stays below 2m
	assign sub_r   = rhsm_pkg::mod_fix({1'b0, t_q} + {1'b0, m} - {1'b0, mm_r}, m);
	assign pos1    = {1'b0, pos_q} + 1'b1;
	assign st_calc = pos1 - {{(PW+1-NW){1'b0}}, pcount_q};
	assign wbase   = rptr_q - pcount_q[IW-1:0];
	assign prd_a   = i_q[IW-1:0];
	assign wrd_a   = (state_q == ST_RP) ? wbase : wbase + i_q[IW-1:0];
	assign out_free = !oval_q || !out_stall;
	assign q_pop   = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		prd_q <= pmem[prd_a];
		wrd_q <= wmem[wrd_a];
		if (state_q == ST_MP && mm_done) pmem[pcount_q[IW-1:0]] <= chr_q;
		if (state_q == ST_WR) wmem[rptr_q] <= chr_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			chr_q <= q_item.chr;
			app_q <= (q_item.op == rhsm_pkg::OP_APPEND);
		end
		if (mm_done) begin
			case (state_q)
				ST_RB: b_q <= mm_r;
				ST_RC: c_q <= mm_r;
				ST_MH: t_q <= sum_c;
				ST_RP: begin
					bpr_q <= mm_r;
					old_q <= wrd_q;
				end
				ST_MS: t_q <= sub_r;
				default: ;
			endcase
		end
		// a window that is not yet full starts at zero
		if (state_q == ST_WR)
			start_q <= (pcount_q == '0) ? pos_q :
				(pos1 >= {{(PW+1-NW){1'b0}}, pcount_q}) ? st_calc[PW-1:0] : '0;
		if (state_q == ST_OUT && out_free) begin
			omatch_q <= hit_q;
			opos_q   <= start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pcount_q <= '0;
			phash_q  <= '0;
			bpow_q   <= 16'd1;
			whash_q  <= '0;
			pos_q    <= '0;
			rptr_q   <= '0;
			i_q      <= '0;
			issued_q <= 1'b0;
			hit_q    <= 1'b0;
			oval_q   <= 1'b0;
		end else begin
			if (oval_q && !out_stall && !(state_q == ST_OUT && out_free)) oval_q <= 1'b0;
			if (mm_start) issued_q <= 1'b1;
			if (mm_done) issued_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.op == rhsm_pkg::OP_RESTART) begin
							pcount_q <= '0;
							phash_q  <= '0;
							bpow_q   <= 16'd1;
							whash_q  <= '0;
							pos_q    <= '0;
							rptr_q   <= '0;
						end else if (q_item.op == rhsm_pkg::OP_TEXT ||
								pcount_q != NW'(rhsm_pkg::MAX_PATTERN)) begin
							state_q <= ST_RB;
						end
					end
				end
				ST_RB: if (mm_done) state_q <= ST_RC;
				ST_RC: if (mm_done) state_q <= ST_MH;
				ST_MH: begin
					if (mm_done) begin
						if (app_q) state_q <= ST_MP;
						else if (pcount_q != '0 &&
								pos_q >= {{(PW-NW){1'b0}}, pcount_q}) state_q <= ST_RP;
						else state_q <= ST_WR;
					end
				end
				ST_MP: begin
					if (mm_done) begin
						bpow_q   <= mm_r;
						phash_q  <= t_q;
						pcount_q <= pcount_q + 1'b1;
						whash_q  <= '0;
						pos_q    <= '0;
						rptr_q   <= '0;
						state_q  <= ST_IDLE;
					end
				end
				ST_RP: if (mm_done) state_q <= ST_MS;
				ST_MS: if (mm_done) state_q <= ST_WR;
				ST_WR: begin
					whash_q <= t_q;
					rptr_q  <= rptr_q + 1'b1;
					if (pos_q != rhsm_pkg::POS_MAX) pos_q <= pos_q + 1'b1;
					hit_q <= 1'b0;
					i_q   <= '0;
					if (pcount_q != '0 && pos1 >= {{(PW+1-NW){1'b0}}, pcount_q})
						state_q <= ST_RH;
					else
						state_q <= ST_OUT;
				end
				ST_RH: begin
					if (mm_done) state_q <= (mm_r == whash_q) ? ST_CMP : ST_OUT;
				end
				ST_CMP: state_q <= ST_CHK;
				ST_CHK: begin
					if (prd_q != wrd_q) begin
						state_q <= ST_OUT;
					end else if (i_q + 1'b1 == pcount_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_CMP;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						oval_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = oval_q;
	assign match_found    = omatch_q;
	assign start_position = opos_q;

	`ASSERT_ALWAYS(a_state_onehot, clk, arst_n, $onehot(state_q))
	`ASSERT_IMPL(a_mm_reduced, clk, arst_n, mm_done, mm_r < m)
	`ASSERT_IMPL(a_hit_full, clk, arst_n, state_q == ST_OUT && hit_q,
		pcount_q != '0 && i_q + 1'b1 == pcount_q)
endmodule
